### src/ppt_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the perspective point transform.
// No dependencies; every other file imports this package.
package ppt_pkg;

  localparam int COORD_W  = 16;
  localparam int CFG_W    = 17;
  localparam int CFG_AW   = 3;
  localparam int FOCAL    = 400;

  // Q16 sine/cosine, range -1.0 .. +1.0
  localparam int TRIG_W   = 18;
  localparam int PAIR_W   = 2 * TRIG_W;
  localparam int E_W      = PAIR_W + TRIG_W;
  localparam int M_W      = 23;

  localparam int V_W      = 21;
  localparam int P_W      = M_W + V_W - 2 + 2;
  localparam int R_W      = P_W + 2;
  localparam int N_W      = R_W + 9;
  localparam int D_W      = R_W;
  localparam int DSH_W    = D_W + COORD_W - 1;

  localparam int Q30_W    = 31;
  localparam int X2_W     = 32;
  localparam int TH_W     = 31;
  localparam int T_W      = 15;
  localparam int RCP_W    = 33;
  localparam int RSH_W    = 6;
  localparam int STEPS    = 5;

  localparam int FULL_TURN    = 92160;
  localparam int QUARTER_TURN = 23040;
  localparam int RAD_PER_UNIT = 73204;

  typedef enum logic [CFG_AW-1:0] {
    REG_ANGLE_X = 3'd0,
    REG_ANGLE_Y = 3'd1,
    REG_ANGLE_Z = 3'd2,
    REG_SHIFT_X = 3'd3,
    REG_SHIFT_Y = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] ax;
    logic signed [CFG_W-1:0] ay;
    logic signed [CFG_W-1:0] az;
  } angles_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] sx;
    logic signed [TRIG_W-1:0] cx;
    logic signed [TRIG_W-1:0] sy;
    logic signed [TRIG_W-1:0] cy;
    logic signed [TRIG_W-1:0] sz;
    logic signed [TRIG_W-1:0] cz;
  } trig_t;

  typedef logic signed [M_W-1:0] mat_t [0:8];

  typedef struct packed {
    logic [N_W-1:0]     rem_x;
    logic [N_W-1:0]     rem_y;
    logic [DSH_W-1:0]   dsh;
    logic [COORD_W-1:0] q_x;
    logic [COORD_W-1:0] q_y;
    logic               neg_x;
    logic               neg_y;
    logic               ovf_x;
    logic               ovf_y;
    logic               fault;
  } div_bus_t;

  typedef struct packed {
    logic [RCP_W-1:0] m;
    logic [RSH_W-1:0] sh;
  } rcp_t;

  // Reciprocal of each series divisor k: floor(n / k) = (n * m) >> sh for any 32-bit n,
  // with sh = 32 + ceil(log2 k) and m = ceil(2^sh / k). Sine pass first, cosine second.
  function automatic rcp_t horner_rcp(input logic cos_pass, input logic [2:0] step);
    rcp_t r;
    case ({cos_pass, step})
      4'b0000: begin r.m = 33'd4997780127; r.sh = 6'd39; end  // 110
      4'b0001: begin r.m = 33'd7635497416; r.sh = 6'd39; end  // 72
      4'b0010: begin r.m = 33'd6544712071; r.sh = 6'd38; end  // 42
      4'b0011: begin r.m = 33'd6871947674; r.sh = 6'd37; end  // 20
      4'b0100: begin r.m = 33'd5726623062; r.sh = 6'd35; end  // 6
      4'b1000: begin r.m = 33'd6108397933; r.sh = 6'd39; end  // 90
      4'b1001: begin r.m = 33'd4908534053; r.sh = 6'd38; end  // 56
      4'b1010: begin r.m = 33'd4581298450; r.sh = 6'd37; end  // 30
      4'b1011: begin r.m = 33'd5726623062; r.sh = 6'd36; end  // 12
      4'b1100: begin r.m = 33'd4294967296; r.sh = 6'd33; end  // 2
      default: begin r.m = 33'd4294967296; r.sh = 6'd32; end
    endcase
    return r;
  endfunction

  // Q30 to Q16 with rounding, capped at 1.0
  function automatic logic [16:0] q30_to_q16(input logic [Q30_W-1:0] v);
    logic [Q30_W:0] s;
    s = {1'b0, v} + (Q30_W + 1)'(8192);
    if (s[Q30_W:14] > 18'd65536) return 17'h10000;
    return s[30:14];
  endfunction

endpackage

### src/perspective_point_transform.sv
`timescale 1ns / 1ps
// Pipeline: 6 arithmetic stages, 16 divider cells and an output register from input item to result.
// Throughput: one point per cycle; each stage holds only while the stage after it is full.
// Reset (rst_n low, synchronous) clears the configuration registers and valid bits, then the
// sine/cosine and the rotation matrix are rebuilt, with in_tready low until they are ready.
// Every angle write starts the same rebuild; shift writes take effect at once.
module perspective_point_transform (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [2*ppt_pkg::COORD_W-1:0] in_tdata,   // in_x, in_y
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [2*ppt_pkg::COORD_W-1:0] out_tdata,  // out_x, out_y
  output logic [1:0]                 out_tuser,     // divide_fault, saturated
  input  logic                       cfg_we,
  input  logic [ppt_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ppt_pkg::CFG_W-1:0]  cfg_wdata
);
  import ppt_pkg::*;

  localparam int FLAG_FAULT = 0;
  localparam int FLAG_SAT   = 1;
  localparam logic signed [P_W-1:0] VZ = P_W'(FOCAL * 16);
  localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  function automatic logic [COORD_W:0] clip_quot(input logic [COORD_W-1:0] q,
                                                 input logic neg, input logic ovf);
    logic [COORD_W-1:0] res;
    if (!neg) begin
      if (ovf || q[COORD_W-1]) return {1'b1, POS_MAX};
      return {1'b0, q};
    end
    if (ovf || (q > NEG_MIN)) return {1'b1, NEG_MIN};
    res = -q;
    return {1'b0, res};
  endfunction

  // configuration
  logic signed [CFG_W-1:0] angle_x_r, angle_y_r, angle_z_r, shift_x_r, shift_y_r;
  logic ang_wr;
  angles_t angles;
  trig_t trig;
  logic trig_ok, mat_ok;
  mat_t mat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_x_r <= '0;
      angle_y_r <= '0;
      angle_z_r <= '0;
      shift_x_r <= '0;
      shift_y_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ANGLE_X: angle_x_r <= cfg_wdata;
        REG_ANGLE_Y: angle_y_r <= cfg_wdata;
        REG_ANGLE_Z: angle_z_r <= cfg_wdata;
        REG_SHIFT_X: shift_x_r <= cfg_wdata;
        REG_SHIFT_Y: shift_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign ang_wr = cfg_we && (cfg_addr == REG_ANGLE_X || cfg_addr == REG_ANGLE_Y ||
                             cfg_addr == REG_ANGLE_Z);
  assign angles = '{ax: angle_x_r, ay: angle_y_r, az: angle_z_r};

  ppt_trig_seq u_trig (
    .clk      (clk),
    .rst_n    (rst_n),
    .ang_wr_i (ang_wr),
    .angles_i (angles),
    .trig_o   (trig),
    .trig_ok_o(trig_ok)
  );

  ppt_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .trig_i   (trig),
    .trig_ok_i(trig_ok),
    .mat_o    (mat),
    .mat_ok_o (mat_ok)
  );

  // pipeline
  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r, vld_e_r, vld_f_r, vld_g_r;
  logic ld_a, ld_b, ld_c, ld_d, ld_e, ld_f, ld_g;
  logic signed [V_W-1:0] vx_a_r, vy_a_r;
  logic signed [P_W-1:0] prod_b_r [0:8];
  logic signed [R_W-1:0] r_c_r [0:2];
  logic signed [N_W-1:0] n_x_d_r, n_y_d_r;
  logic signed [R_W-1:0] d_d_r;
  logic fault_d_r;
  logic [N_W-1:0] an_x_e_r, an_y_e_r;
  logic [D_W-1:0] ad_e_r;
  logic neg_x_e_r, neg_y_e_r, fault_e_r;
  div_bus_t bus_f_r;
  logic cvld [0:COORD_W];
  logic crdy [0:COORD_W];
  div_bus_t cbus [0:COORD_W];
  logic [COORD_W:0] clip_x, clip_y;
  logic [COORD_W-1:0] out_x_r, out_y_r;
  logic fault_g_r, sat_g_r;

  assign ld_g = !vld_g_r || out_tready;
  assign ld_f = !vld_f_r || crdy[0];
  assign ld_e = !vld_e_r || ld_f;
  assign ld_d = !vld_d_r || ld_e;
  assign ld_c = !vld_c_r || ld_d;
  assign ld_b = !vld_b_r || ld_c;
  assign ld_a = !vld_a_r || ld_b;
  assign in_tready = ld_a && mat_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
      vld_g_r <= 1'b0;
    end else begin
      if (ld_a) vld_a_r <= in_tvalid && mat_ok;
      if (ld_b) vld_b_r <= vld_a_r;
      if (ld_c) vld_c_r <= vld_b_r;
      if (ld_d) vld_d_r <= vld_c_r;
      if (ld_e) vld_e_r <= vld_d_r;
      if (ld_f) vld_f_r <= vld_e_r;
      if (ld_g) vld_g_r <= cvld[COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (ld_a) begin
      vx_a_r <= (V_W'($signed(in_tdata[COORD_W-1:0])) <<< 4) + V_W'(shift_x_r);
      vy_a_r <= (V_W'($signed(in_tdata[2*COORD_W-1:COORD_W])) <<< 4) + V_W'(shift_y_r);
    end
    if (ld_b) begin
      for (int i = 0; i < 3; i++) begin
        prod_b_r[3*i]   <= P_W'(mat[3*i]) * P_W'(vx_a_r);
        prod_b_r[3*i+1] <= P_W'(mat[3*i+1]) * P_W'(vy_a_r);
        prod_b_r[3*i+2] <= P_W'(mat[3*i+2]) * VZ;
      end
    end
    if (ld_c) begin
      for (int i = 0; i < 3; i++)
        r_c_r[i] <= R_W'(prod_b_r[3*i]) + R_W'(prod_b_r[3*i+1]) + R_W'(prod_b_r[3*i+2]);
    end
    if (ld_d) begin
      n_x_d_r   <= N_W'(r_c_r[0]) * N_W'(FOCAL);
      n_y_d_r   <= N_W'(r_c_r[1]) * N_W'(FOCAL);
      d_d_r     <= r_c_r[2];
      fault_d_r <= (r_c_r[2] == '0);
    end
    if (ld_e) begin
      an_x_e_r  <= n_x_d_r[N_W-1] ? N_W'(-n_x_d_r) : N_W'(n_x_d_r);
      an_y_e_r  <= n_y_d_r[N_W-1] ? N_W'(-n_y_d_r) : N_W'(n_y_d_r);
      ad_e_r    <= d_d_r[R_W-1] ? D_W'(-d_d_r) : D_W'(d_d_r);
      neg_x_e_r <= n_x_d_r[N_W-1] ^ d_d_r[R_W-1];
      neg_y_e_r <= n_y_d_r[N_W-1] ^ d_d_r[R_W-1];
      fault_e_r <= fault_d_r;
    end
    if (ld_f) begin
      // quotient of 2^16 or more saturates either way
      bus_f_r.ovf_x <= {{(D_W + COORD_W - N_W){1'b0}}, an_x_e_r} >= {ad_e_r, {COORD_W{1'b0}}};
      bus_f_r.ovf_y <= {{(D_W + COORD_W - N_W){1'b0}}, an_y_e_r} >= {ad_e_r, {COORD_W{1'b0}}};
      bus_f_r.rem_x <= an_x_e_r;
      bus_f_r.rem_y <= an_y_e_r;
      bus_f_r.dsh   <= {ad_e_r, {(COORD_W-1){1'b0}}};
      bus_f_r.q_x   <= '0;
      bus_f_r.q_y   <= '0;
      bus_f_r.neg_x <= neg_x_e_r;
      bus_f_r.neg_y <= neg_y_e_r;
      bus_f_r.fault <= fault_e_r;
    end
  end

  assign cvld[0] = vld_f_r;
  assign cbus[0] = bus_f_r;
  assign crdy[COORD_W] = ld_g;

  for (genvar j = 0; j < COORD_W; j++) begin : g_cell
    ppt_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .up_vld_i(cvld[j]),
      .up_rdy_o(crdy[j]),
      .up_i    (cbus[j]),
      .dn_vld_o(cvld[j+1]),
      .dn_rdy_i(crdy[j+1]),
      .dn_o    (cbus[j+1])
    );
  end

  assign clip_x = clip_quot(cbus[COORD_W].q_x, cbus[COORD_W].neg_x, cbus[COORD_W].ovf_x);
  assign clip_y = clip_quot(cbus[COORD_W].q_y, cbus[COORD_W].neg_y, cbus[COORD_W].ovf_y);

  always_ff @(posedge clk) begin
    if (ld_g) begin
      fault_g_r <= cbus[COORD_W].fault;
      if (cbus[COORD_W].fault) begin
        out_x_r <= '0;
        out_y_r <= '0;
        sat_g_r <= 1'b0;
      end else begin
        out_x_r <= clip_x[COORD_W-1:0];
        out_y_r <= clip_y[COORD_W-1:0];
        sat_g_r <= clip_x[COORD_W] || clip_y[COORD_W];
      end
    end
  end

  assign out_tvalid = vld_g_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = {sat_g_r, fault_g_r};

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[FLAG_FAULT] |-> out_tdata == '0 && !out_tuser[FLAG_SAT])
    else $error("fault result carries nonzero data");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[FLAG_SAT] |->
      out_x_r == POS_MAX || out_x_r == NEG_MIN || out_y_r == POS_MAX || out_y_r == NEG_MIN)
    else $error("saturated flag without a clipped coordinate");

  a_ang_stall: assert property (@(posedge clk) disable iff (!rst_n)
    ang_wr |=> !in_tready)
    else $error("input taken while rotation is rebuilt");

endmodule

### src/ppt_trig_seq.sv
`timescale 1ns / 1ps
// Sine/cosine sequencer: series evaluation of the three angles in turn, dividing by a reciprocal multiply.
// Depends on ppt_pkg.
module ppt_trig_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ang_wr_i,
  input  ppt_pkg::angles_t angles_i,
  output ppt_pkg::trig_t   trig_o,
  output logic             trig_ok_o
);
  import ppt_pkg::*;

  typedef enum logic [6:0] {
    SQ_IDLE = 7'b0000001,
    SQ_ANG  = 7'b0000010,
    SQ_SQR  = 7'b0000100,
    SQ_MUL  = 7'b0001000,
    SQ_DIV  = 7'b0010000,
    SQ_UPD  = 7'b0100000,
    SQ_FIN  = 7'b1000000
  } seq_state_t;

  localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;

  seq_state_t state_r, state_nxt;
  logic dirty_r, dirty_nxt;
  logic [1:0] ang_idx_r, quad_r, quad_calc;
  logic [TH_W-1:0] th_r, th_calc;
  logic [X2_W-1:0] x2_r, dvd_r, quot_r;
  logic [Q30_W-1:0] v_r, v_new;
  logic [2:0] step_r;
  logic cos_pass_r;
  rcp_t rcp;
  logic [X2_W+RCP_W-1:0] dq;
  logic [16:0] s_q16_r, c_q16;
  trig_t trig_r;
  logic signed [CFG_W-1:0] ang_sel;
  logic signed [CFG_W:0] ang_ext;
  logic [CFG_W-1:0] wrapped, t_full;
  logic [T_W-1:0] t_calc;
  logic [61:0] thsq, thv;
  logic [62:0] xv;
  logic signed [TRIG_W-1:0] s_s, c_s, sn, cs;

  always_comb begin
    case (ang_idx_r)
      2'd0:    ang_sel = angles_i.ax;
      2'd1:    ang_sel = angles_i.ay;
      default: ang_sel = angles_i.az;
    endcase
    ang_ext = (CFG_W + 1)'(ang_sel);
    if (ang_ext < 0) ang_ext = ang_ext + (CFG_W + 1)'(FULL_TURN);
    wrapped = ang_ext[CFG_W-1:0];
    if (wrapped >= CFG_W'(3 * QUARTER_TURN)) begin
      quad_calc = 2'd3;
      t_full = wrapped - CFG_W'(3 * QUARTER_TURN);
    end else if (wrapped >= CFG_W'(2 * QUARTER_TURN)) begin
      quad_calc = 2'd2;
      t_full = wrapped - CFG_W'(2 * QUARTER_TURN);
    end else if (wrapped >= CFG_W'(QUARTER_TURN)) begin
      quad_calc = 2'd1;
      t_full = wrapped - CFG_W'(QUARTER_TURN);
    end else begin
      quad_calc = 2'd0;
      t_full = wrapped;
    end
    t_calc = t_full[T_W-1:0];
    th_calc = TH_W'(t_calc) * TH_W'(RAD_PER_UNIT);
  end

  assign thsq = 62'(th_r) * 62'(th_r);
  assign xv   = 63'(x2_r) * 63'(v_r);
  assign thv  = 62'(th_r) * 62'(v_r);

  // Divide by the series constant through its reciprocal, exact for 32-bit dividends
  assign rcp = horner_rcp(cos_pass_r, step_r);
  assign dq = (X2_W + RCP_W)'(dvd_r) * (X2_W + RCP_W)'(rcp.m);
  assign v_new = (quot_r >= X2_W'(Q30_ONE)) ? '0 : Q30_ONE - quot_r[Q30_W-1:0];

  assign c_q16 = q30_to_q16(v_r);
  assign s_s = $signed({1'b0, s_q16_r});
  assign c_s = $signed({1'b0, c_q16});

  always_comb begin
    case (quad_r)
      2'd0:    begin sn = s_s;  cs = c_s;  end
      2'd1:    begin sn = c_s;  cs = -s_s; end
      2'd2:    begin sn = -s_s; cs = -c_s; end
      default: begin sn = -c_s; cs = s_s;  end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    dirty_nxt = dirty_r;
    unique case (state_r)
      SQ_IDLE: if (dirty_r) begin
        state_nxt = SQ_ANG;
        dirty_nxt = 1'b0;
      end
      SQ_ANG: state_nxt = SQ_SQR;
      SQ_SQR: state_nxt = SQ_MUL;
      SQ_MUL: state_nxt = SQ_DIV;
      SQ_DIV: state_nxt = SQ_UPD;
      SQ_UPD: state_nxt = (step_r == 3'(STEPS - 1)) ? SQ_FIN : SQ_MUL;
      SQ_FIN: begin
        if (!cos_pass_r) state_nxt = SQ_MUL;
        else if (ang_idx_r == 2'd2) state_nxt = SQ_IDLE;
        else state_nxt = SQ_ANG;
      end
      default: state_nxt = SQ_IDLE;
    endcase
    // a write during a run forces another run
    if (ang_wr_i) dirty_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      dirty_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      SQ_IDLE: ang_idx_r <= '0;
      SQ_ANG: begin
        th_r   <= th_calc;
        quad_r <= quad_calc;
      end
      SQ_SQR: begin
        x2_r       <= thsq[61:30];
        v_r        <= Q30_ONE;
        step_r     <= '0;
        cos_pass_r <= 1'b0;
      end
      SQ_MUL: dvd_r <= xv[61:30];
      SQ_DIV: quot_r <= X2_W'(dq >> rcp.sh);
      SQ_UPD: begin
        v_r    <= v_new;
        step_r <= step_r + 3'd1;
      end
      SQ_FIN: begin
        if (!cos_pass_r) begin
          s_q16_r    <= q30_to_q16(thv[60:30]);
          cos_pass_r <= 1'b1;
          v_r        <= Q30_ONE;
          step_r     <= '0;
        end else begin
          case (ang_idx_r)
            2'd0:    begin trig_r.sx <= sn; trig_r.cx <= cs; end
            2'd1:    begin trig_r.sy <= sn; trig_r.cy <= cs; end
            default: begin trig_r.sz <= sn; trig_r.cz <= cs; end
          endcase
          ang_idx_r <= ang_idx_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign trig_o    = trig_r;
  assign trig_ok_o = (state_r == SQ_IDLE) && !dirty_r;

endmodule

### src/ppt_matrix.sv
`timescale 1ns / 1ps
// Rotation matrix R = Rx*Ry*Rz in Q20, built from the Q16 sines and cosines in three stages.
// Depends on ppt_pkg.
module ppt_matrix (
  input  logic           clk,
  input  logic           rst_n,
  input  ppt_pkg::trig_t trig_i,
  input  logic           trig_ok_i,
  output ppt_pkg::mat_t  mat_o,
  output logic           mat_ok_o
);
  import ppt_pkg::*;

  logic signed [PAIR_W-1:0] cycz_r, cysz_r, sxsy_r, cxsz_r, cxcz_r;
  logic signed [PAIR_W-1:0] sxcy_r, cxsy_r, sxsz_r, sxcz_r, cxcy_r;
  logic signed [TRIG_W-1:0] sy_r, sz_r, cz_r;
  logic signed [E_W-1:0] e_r [0:8];
  logic signed [E_W-1:0] rnd [0:8];
  mat_t mat_r;
  logic [2:0] ok_sh_r;

  always_ff @(posedge clk) begin
    cycz_r <= PAIR_W'(trig_i.cy) * PAIR_W'(trig_i.cz);
    cysz_r <= PAIR_W'(trig_i.cy) * PAIR_W'(trig_i.sz);
    sxsy_r <= PAIR_W'(trig_i.sx) * PAIR_W'(trig_i.sy);
    cxsz_r <= PAIR_W'(trig_i.cx) * PAIR_W'(trig_i.sz);
    cxcz_r <= PAIR_W'(trig_i.cx) * PAIR_W'(trig_i.cz);
    sxcy_r <= PAIR_W'(trig_i.sx) * PAIR_W'(trig_i.cy);
    cxsy_r <= PAIR_W'(trig_i.cx) * PAIR_W'(trig_i.sy);
    sxsz_r <= PAIR_W'(trig_i.sx) * PAIR_W'(trig_i.sz);
    sxcz_r <= PAIR_W'(trig_i.sx) * PAIR_W'(trig_i.cz);
    cxcy_r <= PAIR_W'(trig_i.cx) * PAIR_W'(trig_i.cy);
    sy_r   <= trig_i.sy;
    sz_r   <= trig_i.sz;
    cz_r   <= trig_i.cz;
  end

  // Q48 entries
  always_ff @(posedge clk) begin
    e_r[0] <= E_W'(cycz_r) <<< 16;
    e_r[1] <= -(E_W'(cysz_r) <<< 16);
    e_r[2] <= E_W'(sy_r) <<< 32;
    e_r[3] <= E_W'(sxsy_r) * E_W'(cz_r) + (E_W'(cxsz_r) <<< 16);
    e_r[4] <= (E_W'(cxcz_r) <<< 16) - E_W'(sxsy_r) * E_W'(sz_r);
    e_r[5] <= -(E_W'(sxcy_r) <<< 16);
    e_r[6] <= (E_W'(sxsz_r) <<< 16) - E_W'(cxsy_r) * E_W'(cz_r);
    e_r[7] <= E_W'(cxsy_r) * E_W'(sz_r) + (E_W'(sxcz_r) <<< 16);
    e_r[8] <= E_W'(cxcy_r) <<< 16;
  end

  // Round half up to Q20
  always_comb begin
    for (int i = 0; i < 9; i++) rnd[i] = e_r[i] + E_W'(2 ** 27);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 9; i++) mat_r[i] <= rnd[i][28 +: M_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ok_sh_r <= '0;
    else if (!trig_ok_i) ok_sh_r <= '0;
    else ok_sh_r <= {ok_sh_r[1:0], 1'b1};
  end

  assign mat_o    = mat_r;
  // drop at once when a rebuild starts
  assign mat_ok_o = ok_sh_r[2] && trig_ok_i;

endmodule

### src/ppt_div_cell.sv
`timescale 1ns / 1ps
// One cell of the divider chain: one quotient bit of both coordinates, then hand on.
// Depends on ppt_pkg.
module ppt_div_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_vld_i,
  output logic              up_rdy_o,
  input  ppt_pkg::div_bus_t up_i,
  output logic              dn_vld_o,
  input  logic              dn_rdy_i,
  output ppt_pkg::div_bus_t dn_o
);
  import ppt_pkg::*;

  logic vld_r;
  div_bus_t bus_r, bus_nxt;
  logic ge_x, ge_y;

  assign up_rdy_o = !vld_r || dn_rdy_i;

  always_comb begin
    ge_x = DSH_W'(up_i.rem_x) >= up_i.dsh;
    ge_y = DSH_W'(up_i.rem_y) >= up_i.dsh;
    bus_nxt = up_i;
    bus_nxt.rem_x = ge_x ? up_i.rem_x - up_i.dsh[N_W-1:0] : up_i.rem_x;
    bus_nxt.rem_y = ge_y ? up_i.rem_y - up_i.dsh[N_W-1:0] : up_i.rem_y;
    bus_nxt.q_x = {up_i.q_x[COORD_W-2:0], ge_x};
    bus_nxt.q_y = {up_i.q_y[COORD_W-2:0], ge_y};
    bus_nxt.dsh = up_i.dsh >> 1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else if (up_rdy_o) vld_r <= up_vld_i;
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o) bus_r <= bus_nxt;
  end

  assign dn_vld_o = vld_r;
  assign dn_o     = bus_r;

endmodule
